>>> rtl/core/htd_pkg.sv
// Shared constants, field layout and controller/datapath interface types of the tree decoder.
`default_nettype none

package htd_pkg;

    // Parameter defaults
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int NODE_SLOTS_DEF   = 512;
    localparam int ALPHABET_DEF     = 256;

    // Fixed field widths
    localparam int SYM_W = 8;
    localparam int LEN_W = 6;
    localparam int PAT_W = 32;
    localparam int CNT_W = 32;

    // Request tdata layout, lowest bit first: symbol, code_length, code_pattern, code_bit
    localparam int SYM_LSB    = 0;
    localparam int LEN_LSB    = SYM_LSB + SYM_W;
    localparam int PAT_LSB    = LEN_LSB + LEN_W;
    localparam int BIT_POS    = PAT_LSB + PAT_W;
    localparam int IN_BITS    = BIT_POS + 1;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Result tdata carries decoded_symbol only
    localparam int OUT_TDATA_W = SYM_W;

    // Request kinds (tuser)
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_BIT    = 1'b1;

    // Result status (tuser)
    localparam logic STAT_SYMBOL  = 1'b0;
    localparam logic STAT_MISSING = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // latch request fields, read current node
        logic dec_read;   // pick child for stream bit, read it
        logic emit_err;   // missing branch result, back to root
        logic emit_sym;   // leaf symbol result, back to root
        logic step;       // move to inner node
        logic walk_read;  // read node on insert path
        logic walk_adv;   // descend one existing level
        logic set_sym;    // mark existing final node
        logic link;       // hook first new node to branch point
        logic make;       // write one new node
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_bit;
        logic ins_ok;
        logic total_reached;
        logic next_zero;
        logic leaf;
        logic child_zero;
        logic pos_zero;
        logic fits;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/core/huffman_tree_decoder.sv
// Top level of the bit-serial Huffman tree decoder.
//
// Usage:
//  - s_axis request channel. tuser = kind (0 insert a code, 1 one stream bit).
//    tdata holds symbol, code_length, code_pattern, code_bit (low bits first).
//  - Inserts build the code tree, most significant code bit first; they give
//    no result. An insert that does not fit the node store is dropped whole.
//  - Bit requests walk the tree; on a leaf a result carries the symbol, on a
//    missing branch a result with tuser = 1 and symbol 0; both restart at root.
//  - i_cfg_wen/i_cfg_wdata set symbol_total; write only while idle. Once that
//    many symbols are decoded, bit requests are dropped; tlast marks the last.
// Steps (one request in the block at a time):
//  - Bit request: accept, child read, child check; the result is
//    on m_axis the cycle after the check.
//  - Insert: accept, then a read and a check step per code bit while
//    the path exists; the check at the missing branch links the first new
//    node, then one write per new node. Invalid inserts, dropped bits: accept only.
//  - One result register on m_axis; a stalled receiver holds it, and a new
//    result waits in the check step until the register frees up.
// Reset: synchronous; the tree holds only the root, count and total are zero.
`default_nettype none

module huffman_tree_decoder
    import htd_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int NODE_SLOTS   = NODE_SLOTS_DEF,
    parameter int ALPHABET     = ALPHABET_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // request channel
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: symbol[7:0], code_length[13:8], code_pattern[45:14], code_bit[46], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: kind
    input  wire logic                   s_axis_tuser,
    // result channel
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: decoded_symbol[7:0]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: status
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast,
    // symbol_total register
    input  wire logic                   i_cfg_wen,
    input  wire logic [CNT_W-1:0]       i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    htd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    htd_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NODE_SLOTS   (NODE_SLOTS),
        .ALPHABET     (ALPHABET)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/core/htd_ram.sv
// Generic single write port RAM with registered, enabled read.
`default_nettype none

module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/htd_ctrl.sv
// Sequencer of the tree decoder: bit decode and code insert walks.
`default_nettype none

module htd_ctrl
    import htd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_B_CHILD = 7'b0000010,
        S_B_EVAL  = 7'b0000100,
        S_I_RD    = 7'b0001000,
        S_I_CHK   = 7'b0010000,
        S_I_NEW   = 7'b0100000,
        S_SPARE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.is_bit) begin
                        if (!i_stat.total_reached) begin
                            n_state = S_B_CHILD;
                        end
                    end else if (i_stat.ins_ok) begin
                        n_state = S_I_RD;
                    end
                end
            end
            S_B_CHILD: begin
                o_cmd.dec_read = 1'b1;
                n_state        = S_B_EVAL;
            end
            S_B_EVAL: begin
                if (i_stat.next_zero) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_err = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_stat.leaf) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_sym = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_I_RD: begin
                o_cmd.walk_read = 1'b1;
                n_state         = S_I_CHK;
            end
            S_I_CHK: begin
                if (!i_stat.child_zero) begin
                    if (i_stat.pos_zero) begin
                        o_cmd.set_sym = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.walk_adv = 1'b1;
                        n_state        = S_I_RD;
                    end
                end else if (i_stat.fits) begin
                    o_cmd.link = 1'b1;
                    n_state    = S_I_NEW;
                end else begin
                    n_state = S_IDLE;   // store full: drop whole insert
                end
            end
            S_I_NEW: begin
                o_cmd.make = 1'b1;
                if (i_stat.pos_zero) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/htd_datapath.sv
// Node store, walk registers, counters and result register of the tree decoder.
`default_nettype none

module htd_datapath
    import htd_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int NODE_SLOTS   = NODE_SLOTS_DEF,
    parameter int ALPHABET     = ALPHABET_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_s_tuser,
    input  wire logic                   i_cfg_wen,
    input  wire logic [CNT_W-1:0]       i_cfg_wdata,
    input  wire logic                   i_m_tready,
    output logic                        o_m_tvalid,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                        o_m_tuser,
    output logic                        o_m_tlast
);

    localparam int NW   = $clog2(NODE_SLOTS);
    localparam int CW   = $clog2(NODE_SLOTS + 1);
    localparam int SW   = ((CW > LEN_W) ? CW : LEN_W) + 1;
    localparam int PI_W = $clog2(PAT_W);

    function automatic logic f_path_bit(input logic [PAT_W-1:0] pat,
                                        input logic [LEN_W-1:0] pos);
        logic b;
        b = 1'b0;
        if (pos < LEN_W'(PAT_W)) begin
            b = pat[pos[PI_W-1:0]];
        end
        return b;
    endfunction

    // control state
    logic [NW-1:0]    r_cur;
    logic [NW-1:0]    r_root_l, r_root_r;
    logic [CW-1:0]    r_nodes_used;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_total;
    logic             r_out_valid;

    // payload
    logic             r_bit;
    logic [SYM_W-1:0] r_sym;
    logic [PAT_W-1:0] r_pat;
    logic [LEN_W-1:0] r_pos;
    logic [NW-1:0]    r_node;
    logic [NW-1:0]    r_next;
    logic             r_rd_root;
    logic             r_out_status;
    logic [SYM_W-1:0] r_out_sym;
    logic             r_out_last;

    logic [NW-1:0]    ram_l_q, ram_r_q;
    logic [SYM_W-1:0] ram_s_q;
    logic [NW-1:0]    cl_l, cl_r, dec_next, walk_c;
    logic             pbit, nbit, more;
    logic             rd_en;
    logic [NW-1:0]    rd_addr;
    logic [NW-1:0]    new_idx, nxt_ptr, node_waddr, sym_waddr;
    logic             l_we, r_we, sym_we;
    logic [NW-1:0]    l_wdata, r_wdata;
    logic [LEN_W-1:0] in_len;
    logic [SYM_W-1:0] in_sym;

    assign in_len = i_s_tdata[LEN_LSB +: LEN_W];
    assign in_sym = i_s_tdata[SYM_LSB +: SYM_W];

    // children of the node read last; root lives in flops
    assign cl_l     = r_rd_root ? r_root_l : ram_l_q;
    assign cl_r     = r_rd_root ? r_root_r : ram_r_q;
    assign pbit     = f_path_bit(r_pat, r_pos);
    assign nbit     = f_path_bit(r_pat, r_pos - LEN_W'(1));
    assign dec_next = r_bit ? cl_r : cl_l;
    assign walk_c   = pbit ? cl_r : cl_l;
    assign more     = (r_pos != '0);

    always_comb begin
        o_stat.is_bit        = (i_s_tuser == KIND_BIT);
        o_stat.ins_ok        = (in_len != '0)
                             && ({2'b00, in_len} <= (LEN_W+2)'(MAX_CODE_LEN))
                             && ({1'b0, in_sym} < (SYM_W+1)'(ALPHABET));
        o_stat.total_reached = (r_count >= r_total);
        o_stat.next_zero     = (r_next == '0);
        o_stat.leaf          = (ram_l_q == '0) && (ram_r_q == '0);
        o_stat.child_zero    = (walk_c == '0);
        o_stat.pos_zero      = !more;
        o_stat.fits          = (SW'(r_nodes_used) + SW'(r_pos) + SW'(1)) <= SW'(NODE_SLOTS);
        o_stat.out_free      = !r_out_valid || i_m_tready;
    end

    // read port: current node, chosen child, or insert path node
    assign rd_en   = i_cmd.capture || i_cmd.dec_read || i_cmd.walk_read;
    assign rd_addr = i_cmd.capture  ? r_cur :
                     i_cmd.dec_read ? dec_next : r_node;

    // write port: link at branch point, then a run of fresh nodes
    assign new_idx    = NW'(r_nodes_used);
    assign nxt_ptr    = NW'(r_nodes_used + CW'(1));
    assign node_waddr = i_cmd.make ? new_idx : r_node;
    assign l_we       = i_cmd.make || (i_cmd.link && !pbit && (r_node != '0));
    assign r_we       = i_cmd.make || (i_cmd.link &&  pbit && (r_node != '0));
    assign l_wdata    = i_cmd.make ? ((more && !nbit) ? nxt_ptr : '0) : new_idx;
    assign r_wdata    = i_cmd.make ? ((more &&  nbit) ? nxt_ptr : '0) : new_idx;
    assign sym_we     = i_cmd.set_sym || (i_cmd.make && !more);
    assign sym_waddr  = i_cmd.make ? new_idx : walk_c;

    htd_ram #(.WIDTH(NW), .DEPTH(NODE_SLOTS)) u_left (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (node_waddr),
        .i_wdata (l_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_l_q)
    );

    htd_ram #(.WIDTH(NW), .DEPTH(NODE_SLOTS)) u_right (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (node_waddr),
        .i_wdata (r_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_r_q)
    );

    htd_ram #(.WIDTH(SYM_W), .DEPTH(NODE_SLOTS)) u_sym (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (sym_waddr),
        .i_wdata (r_sym),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_s_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= '0;
            r_root_l     <= '0;
            r_root_r     <= '0;
            r_nodes_used <= CW'(1);
            r_count      <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_total <= i_cfg_wdata;
            end
            if (i_cmd.emit_err || i_cmd.emit_sym) begin
                r_cur <= '0;
            end else if (i_cmd.step) begin
                r_cur <= r_next;
            end
            if (i_cmd.link && (r_node == '0)) begin
                if (pbit) begin
                    r_root_r <= new_idx;
                end else begin
                    r_root_l <= new_idx;
                end
            end
            if (i_cmd.make) begin
                r_nodes_used <= r_nodes_used + CW'(1);
            end
            if (i_cmd.emit_sym) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.emit_err || i_cmd.emit_sym) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_bit  <= i_s_tdata[BIT_POS];
            r_sym  <= in_sym;
            r_pat  <= i_s_tdata[PAT_LSB +: PAT_W];
            r_pos  <= in_len - LEN_W'(1);
            r_node <= '0;
        end else if (i_cmd.walk_adv) begin
            r_node <= walk_c;
            r_pos  <= r_pos - LEN_W'(1);
        end else if (i_cmd.make && more) begin
            r_pos  <= r_pos - LEN_W'(1);
        end
        if (i_cmd.dec_read) begin
            r_next <= dec_next;
        end
        if (rd_en) begin
            r_rd_root <= (rd_addr == '0);
        end
        if (i_cmd.emit_err) begin
            r_out_status <= STAT_MISSING;
            r_out_sym    <= '0;
            r_out_last   <= 1'b0;
        end else if (i_cmd.emit_sym) begin
            r_out_status <= STAT_SYMBOL;
            r_out_sym    <= ram_s_q;
            r_out_last   <= ((r_count + CNT_W'(1)) == r_total);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_sym;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_nodes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nodes_used != '0) && (r_nodes_used <= CW'(NODE_SLOTS)))
        else $error("node count out of range");

    a_make_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.make |-> (r_nodes_used < CW'(NODE_SLOTS)))
        else $error("node written past store end");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_err || i_cmd.emit_sym) |-> (!r_out_valid || i_m_tready))
        else $error("result overwrites pending result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_sym |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("decoded count did not advance");

    a_cur_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_cur) < r_nodes_used)
        else $error("current node not allocated");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench of the bit-serial Huffman tree decoder.
`timescale 1ns / 100ps

module tb_top
    import htd_pkg::*;
;

    localparam int          NODES      = NODE_SLOTS_DEF;
    localparam int          NW         = $clog2(NODE_SLOTS_DEF);
    localparam int          RAND_GOAL  = 1900;  // live requests in the random part
    localparam int          CALM_TAIL  = 400;   // last live requests run without idling
    localparam int          PHASE_CAP  = 160;   // requests per phase, at most
    localparam int          FILL_PHASE = 6;     // phase that runs the node store full
    localparam int          LOW_PHASE  = 3;     // phase with the total below the count
    localparam int          MAX_PHASE  = 5;     // phase with the total at its maximum
    localparam int          SETTLE_CYC = 160;   // long enough for the worst insert walk
    localparam int unsigned LIMIT_NS   = 10_000_000;

    // ---------------------------------------------------------------- types
    typedef struct packed {
        logic             status;
        logic [SYM_W-1:0] sym;
        logic             last;
    } sym_res_t;

    typedef struct packed {
        logic             kind;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
        logic             cb;
    } req_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } code_t;

    typedef enum logic [1:0] {INS_DONE, INS_FULL, INS_SKIP} ins_t;
    typedef enum logic [1:0] {STEP_IGNORED, STEP_INNER, STEP_RESULT} step_t;
    typedef enum logic [1:0] {ROW_INS, ROW_BIT, ROW_WALK, ROW_CFG} row_op_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_TYPED} chk_t;

    // one directed row; val is the code pattern, or the total for ROW_CFG
    typedef struct packed {
        row_op_t          op;
        chk_t             chk;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] val;
        logic             cb;
        sym_res_t         want;
    } dir_row_t;

    localparam sym_res_t NO_RES   = '0;
    localparam int       DIR_ROWS = 22;

    // ---------------------------------------------------------------- DUT I/O
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: symbol, code_length, code_pattern, code_bit, zero pad
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
    // tuser: kind
    logic                  s_axis_tuser  = KIND_INSERT;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    // tdata: decoded_symbol
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // tuser: status
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  i_cfg_wen     = 1'b0;
    logic [CNT_W-1:0]      i_cfg_wdata   = '0;

    huffman_tree_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------- tree predictor state
    logic [NW-1:0]    left_of  [NODES];
    logic [NW-1:0]    right_of [NODES];
    logic [SYM_W-1:0] mark_of  [NODES];
    int unsigned      nodes_taken;
    logic [NW-1:0]    walk_pos;
    logic [CNT_W-1:0] syms_done;
    logic [CNT_W-1:0] syms_wanted;

    sym_res_t    pending_syms [$];   // expected results, oldest first
    code_t       known_codes  [$];   // codes that made it into the tree
    sym_res_t    head_res;
    logic        idle_on = 1'b1;
    int unsigned rx_gap  = 0;
    int unsigned fail_cnt, live_items, sent_items;
    int unsigned inserts_built, inserts_dropped, total_writes;
    int unsigned syms_seen, misses_seen;

    // Insert walk: overlong codes are skipped; a dry run counts the new nodes; the insert is dropped whole
    // if the store can't take them, else the path is built and the end marked.
    function automatic ins_t tree_insert(input logic [SYM_W-1:0] sym,
                                         input logic [LEN_W-1:0] len,
                                         input logic [PAT_W-1:0] pat);
        logic [NW-1:0] node;
        logic [NW-1:0] nxt;
        int unsigned   need;
        logic          off;
        int            i;
        if (len > MAX_CODE_LEN_DEF) return INS_SKIP;
        node = '0;
        need = 0;
        off  = 1'b0;
        for (i = int'(len) - 1; i >= 0; i--) begin
            if (off) begin
                need++;
            end else begin
                nxt = pat[i] ? right_of[node] : left_of[node];
                if (nxt == '0) begin
                    off = 1'b1;
                    need++;
                end else begin
                    node = nxt;
                end
            end
        end
        if (nodes_taken + need > NODES) return INS_FULL;
        node = '0;
        for (i = int'(len) - 1; i >= 0; i--) begin
            nxt = pat[i] ? right_of[node] : left_of[node];
            if (nxt == '0) begin
                nxt = nodes_taken[NW-1:0];
                nodes_taken++;
                left_of[nxt]  = '0;
                right_of[nxt] = '0;
                mark_of[nxt]  = '0;
                if (pat[i]) right_of[node] = nxt;
                else        left_of[node]  = nxt;
            end
            node = nxt;
        end
        mark_of[node] = sym;  // empty code lands on the root, never visible
        return INS_DONE;
    endfunction

    // One stream bit: missing branch -> miss, childless node -> symbol.
    function automatic step_t tree_bit(input logic cb, output sym_res_t res);
        logic [NW-1:0] nxt;
        res = NO_RES;
        if (syms_done >= syms_wanted) return STEP_IGNORED;
        nxt = cb ? right_of[walk_pos] : left_of[walk_pos];
        if (nxt == '0) begin
            walk_pos   = '0;
            res.status = STAT_MISSING;
            return STEP_RESULT;
        end
        if (left_of[nxt] == '0 && right_of[nxt] == '0) begin
            syms_done++;
            res.status = STAT_SYMBOL;
            res.sym    = mark_of[nxt];
            res.last   = (syms_done == syms_wanted);
            walk_pos   = '0;
            return STEP_RESULT;
        end
        walk_pos = nxt;
        return STEP_INNER;
    endfunction

    // ---------------------------------------------------------------- request side
    // Leaves tvalid high after the handshake; whoever pauses lowers it.
    task automatic send_req(input req_t rq, input logic model_exp);
        logic [IN_TDATA_W-1:0] td;
        sym_res_t              res;
        step_t                 st;
        ins_t                  ir;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        td                     = '0;
        td[SYM_LSB +: SYM_W]   = rq.sym;
        td[LEN_LSB +: LEN_W]   = rq.len;
        td[PAT_LSB +: PAT_W]   = rq.pat;
        td[BIT_POS]            = rq.cb;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= td;
        s_axis_tuser  <= rq.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
        if (rq.kind == KIND_INSERT) begin
            ir = tree_insert(rq.sym, rq.len, rq.pat);
            if (ir == INS_DONE) begin
                inserts_built++;
                live_items++;
                if (rq.len != '0) known_codes.push_back({rq.len, rq.pat});
            end else if (ir == INS_FULL) begin
                inserts_dropped++;
            end
        end else begin
            st = tree_bit(rq.cb, res);
            if (st != STEP_IGNORED) live_items++;
            if (st == STEP_RESULT && model_exp) pending_syms.push_back(res);
        end
    endtask

    function automatic req_t rand_insert(input logic [LEN_W-1:0] len);
        req_t rq;
        rq      = '0;
        rq.kind = KIND_INSERT;
        rq.sym  = SYM_W'($urandom);
        rq.len  = len;
        rq.pat  = $urandom;
        rq.cb   = 1'($urandom);
        return rq;
    endfunction

    // Feed a code as stream bits, first code bit = bit len-1 of the pattern.
    task automatic walk_code(input code_t c);
        req_t rq;
        int   i;
        for (i = int'(c.len) - 1; i >= 0; i--) begin
            rq      = '0;
            rq.kind = KIND_BIT;
            rq.sym  = SYM_W'($urandom);
            rq.len  = LEN_W'($urandom);
            rq.pat  = $urandom;
            rq.cb   = c.pat[i];
            send_req(rq, 1'b1);
        end
    endtask

    task automatic send_noise_bits(input int n);
        req_t rq;
        repeat (n) begin
            rq      = rand_insert(LEN_W'($urandom));
            rq.kind = KIND_BIT;
            send_req(rq, 1'b1);
        end
    endtask

    // Sender holds off until every result is in, then lets a pending insert walk finish.
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (pending_syms.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_total(input logic [CNT_W-1:0] v);
        drain_and_settle();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        syms_wanted  = v;
        total_writes++;
    endtask

    // ---------------------------------------------------------------- result side
    // Random tready stall bursts while idling is on.
    always @(posedge i_clk) begin
        if (idle_on && rx_gap == 0 && $urandom_range(0, 5) == 0) begin
            rx_gap        <= $urandom_range(1, 14);
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 1) begin
            rx_gap <= rx_gap - 1;
        end else begin
            rx_gap        <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (m_axis_tuser == STAT_MISSING) misses_seen++;
            else                              syms_seen++;
            if (pending_syms.size() == 0) begin
                $display("%0t: result with none expected: status %0b symbol %02h last %0b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                fail_cnt++;
            end else begin
                head_res = pending_syms.pop_front();
                if (m_axis_tuser !== head_res.status || m_axis_tdata !== head_res.sym ||
                    m_axis_tlast !== head_res.last) begin
                    $display({"%0t: result mismatch: expected status %0b symbol %02h last %0b,",
                              " got status %0b symbol %02h last %0b"},
                             $time, head_res.status, head_res.sym, head_res.last,
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- directed rows
    // Tree after the inserts: "0"=00, "10"=FF, 32 ones=80; then "00"=33 turns
    // "0" into an inner node. Total 6 makes the sixth symbol the last one.
    dir_row_t dir_tab [DIR_ROWS] = '{
        // total is zero out of reset: bit is dropped
        '{ROW_BIT,  CHK_QUIET, 8'h00, 6'd0,  32'h0000_0000, 1'b0, NO_RES},
        '{ROW_CFG,  CHK_QUIET, 8'h00, 6'd0,  32'd6,         1'b0, NO_RES},
        // empty tree: missing branch
        '{ROW_BIT,  CHK_TYPED, 8'h00, 6'd0,  32'h0000_0000, 1'b1,
          '{STAT_MISSING, 8'h00, 1'b0}},
        '{ROW_INS,  CHK_QUIET, 8'h00, 6'd1,  32'h0000_0000, 1'b0, NO_RES},
        '{ROW_INS,  CHK_QUIET, 8'hFF, 6'd2,  32'hFFFF_FFFE, 1'b1, NO_RES},
        // empty code: the DUT drops it, the model marks the root only
        '{ROW_INS,  CHK_QUIET, 8'h5A, 6'd0,  32'hFFFF_FFFF, 1'b1, NO_RES},
        // overlong codes are dropped
        '{ROW_INS,  CHK_QUIET, 8'h11, 6'd33, 32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_INS,  CHK_QUIET, 8'h22, 6'd63, 32'h0000_0000, 1'b1, NO_RES},
        '{ROW_INS,  CHK_QUIET, 8'h80, 6'd32, 32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_BIT,  CHK_TYPED, 8'h00, 6'd0,  32'h0000_0000, 1'b0,
          '{STAT_SYMBOL, 8'h00, 1'b0}},
        '{ROW_BIT,  CHK_QUIET, 8'h00, 6'd0,  32'h0000_0000, 1'b1, NO_RES},
        '{ROW_BIT,  CHK_TYPED, 8'h00, 6'd0,  32'h0000_0000, 1'b0,
          '{STAT_SYMBOL, 8'hFF, 1'b0}},
        '{ROW_WALK, CHK_MODEL, 8'h00, 6'd32, 32'hFFFF_FFFF, 1'b0, NO_RES},
        // "11" exists, "110" does not
        '{ROW_WALK, CHK_MODEL, 8'h00, 6'd3,  32'h0000_0006, 1'b0, NO_RES},
        // extends leaf "0": codes stop being prefix-free
        '{ROW_INS,  CHK_QUIET, 8'h33, 6'd2,  32'h0000_0000, 1'b0, NO_RES},
        '{ROW_WALK, CHK_MODEL, 8'h00, 6'd2,  32'h0000_0000, 1'b0, NO_RES},
        '{ROW_WALK, CHK_MODEL, 8'h00, 6'd2,  32'h0000_0001, 1'b0, NO_RES},
        '{ROW_WALK, CHK_MODEL, 8'h00, 6'd2,  32'h0000_0002, 1'b0, NO_RES},
        '{ROW_BIT,  CHK_QUIET, 8'h00, 6'd0,  32'h0000_0000, 1'b0, NO_RES},
        '{ROW_BIT,  CHK_TYPED, 8'h00, 6'd0,  32'h0000_0000, 1'b0,
          '{STAT_SYMBOL, 8'h33, 1'b1}},
        // total reached: dropped
        '{ROW_BIT,  CHK_QUIET, 8'h00, 6'd0,  32'h0000_0000, 1'b1, NO_RES},
        '{ROW_CFG,  CHK_QUIET, 8'h00, 6'd0,  32'hFFFF_FFFF, 1'b0, NO_RES}
    };

    // ---------------------------------------------------------------- stimulus
    initial begin : stim
        dir_row_t         row;
        req_t             rq;
        int               ph;
        int unsigned      goal, phase_start, drops, k, sel;
        logic [LEN_W-1:0] ln;
        for (k = 0; k < NODES; k++) begin
            left_of[k]  = '0;
            right_of[k] = '0;
            mark_of[k]  = '0;
        end
        nodes_taken = 1;
        walk_pos    = '0;
        syms_done   = '0;
        syms_wanted = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            row = dir_tab[r];
            case (row.op)
                ROW_CFG:  set_total(row.val);
                ROW_WALK: walk_code({row.len, row.val});
                default: begin
                    rq.kind = (row.op == ROW_INS) ? KIND_INSERT : KIND_BIT;
                    rq.sym  = row.sym;
                    rq.len  = row.len;
                    rq.pat  = row.val;
                    rq.cb   = row.cb;
                    if (row.chk == CHK_TYPED) pending_syms.push_back(row.want);
                    send_req(rq, row.chk == CHK_MODEL);
                end
            endcase
        end

        // Random phases: each sets a fresh total, then mostly walks known codes,
        // with some noise bits (broken walks, misses) and new inserts.
        goal = live_items + RAND_GOAL;
        ph   = 0;
        while (live_items < goal) begin
            if (live_items + CALM_TAIL > goal) idle_on <= 1'b0;
            else                               idle_on <= ($urandom_range(0, 3) != 0);
            if (ph == LOW_PHASE)      set_total(syms_done >> 1);
            else if (ph == MAX_PHASE) set_total('1);
            else                      set_total(syms_done + $urandom_range(8, 40));

            if (ph == FILL_PHASE) begin
                // long codes until the store turns two inserts away, or 60 tries
                drops = inserts_dropped;
                k     = 0;
                while (inserts_dropped < drops + 2 && k < 60) begin
                    send_req(rand_insert(LEN_W'(MAX_CODE_LEN_DEF)), 1'b1);
                    k++;
                end
            end

            phase_start = sent_items;
            while (syms_done < syms_wanted && sent_items - phase_start < PHASE_CAP) begin
                sel = $urandom_range(0, 99);
                if (sel < ((ph < FILL_PHASE) ? 15 : 6) || known_codes.size() == 0) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 5)       ln = '0;
                    else if (sel < 12) ln = LEN_W'($urandom_range(33, 63));
                    else if (sel < 75) ln = LEN_W'($urandom_range(1, 8));
                    else               ln = LEN_W'($urandom_range(9, MAX_CODE_LEN_DEF));
                    send_req(rand_insert(ln), 1'b1);
                end else if (sel < 30) begin
                    send_noise_bits($urandom_range(1, 5));
                end else begin
                    walk_code(known_codes[$urandom_range(0, known_codes.size() - 1)]);
                end
            end
            // a few bits past the total, or dropped with the total below the count
            send_noise_bits((ph == LOW_PHASE) ? 8 : $urandom_range(1, 3));
            ph++;
        end

        drain_and_settle();
        $display("tb: %0d requests taken, %0d inserts built, %0d turned away for space",
                 sent_items, inserts_built, inserts_dropped);
        $display("tb: %0d symbols and %0d misses checked over %0d total settings",
                 syms_seen, misses_seen, total_writes);
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("tb: run timed out with %0d results outstanding", pending_syms.size());
        $display("tb: failure");
        $finish;
    end

endmodule

>>> huffman_tree_decoder.f
rtl/core/htd_pkg.sv
rtl/core/htd_ram.sv
rtl/core/htd_ctrl.sv
rtl/core/htd_datapath.sv
rtl/core/huffman_tree_decoder.sv
tb/sv/tb_top.sv
